// File: hdl/dssr_pkg.sv
package dssr_pkg;

	localparam int COUNT_BITS     = 8;
	localparam int PHASE_COUNT    = 4;
	localparam int PHASE_BITS     = $clog2(PHASE_COUNT);
	localparam int COIL_BITS      = 4;
	localparam int PORT_BITS      = 2 * COIL_BITS;
	localparam int ERR_BITS       = 8;
	localparam int BASE_BITS      = 10;
	localparam int GAIN_BITS      = 8;
	localparam int DIV_BITS       = 16;
	localparam int DIV_CNT_BITS   = $clog2(DIV_BITS);
	localparam int CFG_IDX_BITS   = 3;
	localparam int CFG_DATA_BITS  = 16;
	localparam int QUEUE_DEPTH    = 2;
	localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

	localparam logic [BASE_BITS-1:0]  BASE_RESET       = BASE_BITS'(300);
	localparam logic [GAIN_BITS-1:0]  GAIN_SMALL_RESET = GAIN_BITS'(140);
	localparam logic [GAIN_BITS-1:0]  GAIN_MID_RESET   = GAIN_BITS'(120);
	localparam logic [GAIN_BITS-1:0]  GAIN_LARGE_RESET = GAIN_BITS'(100);
	localparam logic [DIV_BITS-1:0]   TICK_RATE_RESET  = DIV_BITS'(15625);
	localparam logic [COUNT_BITS-1:0] COMPARE_RESET    = '1;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_BASE_SPEED = 3'd0,
		REG_GAIN_SMALL = 3'd1,
		REG_GAIN_MID   = 3'd2,
		REG_GAIN_LARGE = 3'd3,
		REG_TICK_RATE  = 3'd4
	} cfg_reg_t;

	typedef enum logic [1:0] {
		OP_TICK,
		OP_BOTH,
		OP_MOTOR1,
		OP_MOTOR2
	} op_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} back_state_t;

	typedef struct packed {
		op_t                 op;
		logic [DIV_BITS-1:0] pps;
	} cmd_t;

	typedef struct packed {
		logic                     we;
		logic [CFG_IDX_BITS-1:0]  index;
		logic [CFG_DATA_BITS-1:0] data;
	} cfg_wr_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	// motor 1 coils walk down from the top bit, motor 2 coils walk up
	function automatic logic [COIL_BITS-1:0] m1_coil(input logic [PHASE_BITS-1:0] ph);
		logic [COIL_BITS-1:0] base;
		base = {1'b1, {(COIL_BITS-1){1'b0}}};
		return base >> ph;
	endfunction

	function automatic logic [COIL_BITS-1:0] m2_coil(input logic [PHASE_BITS-1:0] ph);
		logic [COIL_BITS-1:0] base;
		base = {{(COIL_BITS-1){1'b0}}, 1'b1};
		return base << ph;
	endfunction

endpackage

// File: hdl/dssr_req_if.sv
interface dssr_req_if;
	logic                              valid;
	logic                              ready;
	logic                              req_type;
	logic signed [dssr_pkg::ERR_BITS-1:0] line_error;

	modport source (output valid, output req_type, output line_error, input ready);
	modport sink (input valid, input req_type, input line_error, output ready);
endinterface

// File: hdl/dssr_rsp_if.sv
interface dssr_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [dssr_pkg::PORT_BITS-1:0]   port_value;
	logic                             motor1_stepped;
	logic                             motor2_stepped;

	modport source (output valid, output port_value, output motor1_stepped,
		output motor2_stepped, input ready);
	modport sink (input valid, input port_value, input motor1_stepped,
		input motor2_stepped, output ready);
endinterface

// File: hdl/dssr_front.sv
module dssr_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dssr_pkg::cfg_wr_t     cfg,
	dssr_req_if.sink              req,
	input  dssr_pkg::queue_stat_t q_stat,
	output logic                  push,
	output dssr_pkg::cmd_t        cmd
);

	logic [dssr_pkg::BASE_BITS-1:0] base_q;
	logic [dssr_pkg::GAIN_BITS-1:0] gain_small_q;
	logic [dssr_pkg::GAIN_BITS-1:0] gain_mid_q;
	logic [dssr_pkg::GAIN_BITS-1:0] gain_large_q;

	logic                                           neg;
	logic [dssr_pkg::ERR_BITS-1:0]                  mag;
	logic [dssr_pkg::GAIN_BITS-1:0]                 gain;
	logic [dssr_pkg::ERR_BITS+dssr_pkg::GAIN_BITS-1:0] prod;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q       <= dssr_pkg::BASE_RESET;
			gain_small_q <= dssr_pkg::GAIN_SMALL_RESET;
			gain_mid_q   <= dssr_pkg::GAIN_MID_RESET;
			gain_large_q <= dssr_pkg::GAIN_LARGE_RESET;
		end else if (cfg.we) begin
			unique case (cfg.index)
				dssr_pkg::REG_BASE_SPEED: base_q <= cfg.data[dssr_pkg::BASE_BITS-1:0];
				dssr_pkg::REG_GAIN_SMALL: gain_small_q <= cfg.data[dssr_pkg::GAIN_BITS-1:0];
				dssr_pkg::REG_GAIN_MID:   gain_mid_q <= cfg.data[dssr_pkg::GAIN_BITS-1:0];
				dssr_pkg::REG_GAIN_LARGE: gain_large_q <= cfg.data[dssr_pkg::GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// classify: tick, zero error, or one side speeds up
	always_comb begin
		neg = req.line_error[dssr_pkg::ERR_BITS-1];
		mag = neg ? (~req.line_error + 1'b1) : req.line_error;
		priority if (mag == dssr_pkg::ERR_BITS'(1)) begin
			gain = gain_small_q;
		end else if (mag == dssr_pkg::ERR_BITS'(2)) begin
			gain = gain_mid_q;
		end else begin
			gain = gain_large_q;
		end
		prod    = mag * gain;
		cmd.pps = dssr_pkg::DIV_BITS'(base_q) + dssr_pkg::DIV_BITS'(prod);
		priority if (!req.req_type) begin
			cmd.op = dssr_pkg::OP_TICK;
		end else if (mag == '0) begin
			cmd.op = dssr_pkg::OP_BOTH;
		end else if (neg) begin
			cmd.op = dssr_pkg::OP_MOTOR1;
		end else begin
			cmd.op = dssr_pkg::OP_MOTOR2;
		end
	end

	assign req.ready = !q_stat.full;
	assign push      = req.valid && !q_stat.full;

endmodule

// File: hdl/dssr_queue.sv
module dssr_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  dssr_pkg::cmd_t        push_cmd,
	input  logic                  pop,
	output dssr_pkg::cmd_t        head,
	output dssr_pkg::queue_stat_t q_stat
);

	dssr_pkg::cmd_t                      mem_q [dssr_pkg::QUEUE_DEPTH];
	logic [dssr_pkg::QUEUE_PTR_BITS-1:0] wr_ptr_q;
	logic [dssr_pkg::QUEUE_PTR_BITS-1:0] rd_ptr_q;
	logic [dssr_pkg::QUEUE_PTR_BITS:0]   fill_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	assign head         = mem_q[rd_ptr_q];
	assign q_stat.full  = (fill_q == (dssr_pkg::QUEUE_PTR_BITS+1)'(dssr_pkg::QUEUE_DEPTH));
	assign q_stat.empty = (fill_q == '0);

endmodule

// File: hdl/dssr_back.sv
module dssr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dssr_pkg::cfg_wr_t     cfg,
	input  dssr_pkg::cmd_t        head,
	input  dssr_pkg::queue_stat_t q_stat,
	output logic                  pop,
	dssr_rsp_if.source            rsp
);

	localparam int CB = dssr_pkg::COUNT_BITS;
	localparam int DB = dssr_pkg::DIV_BITS;
	localparam int CW = dssr_pkg::COIL_BITS;

	dssr_pkg::back_state_t state_q, state_d;

	logic [DB-1:0]                       tick_rate_q;
	logic [CB-1:0]                       count1_q, count2_q;
	logic [CB-1:0]                       cmp1_q, cmp2_q;
	logic                                en1_q, en2_q;
	logic [dssr_pkg::PHASE_BITS-1:0]     ph1_q, ph2_q;
	logic [dssr_pkg::PORT_BITS-1:0]      port_q;
	logic                                out_valid_q;
	logic [dssr_pkg::PORT_BITS-1:0]      out_port_q;
	logic                                out_st1_q, out_st2_q;

	dssr_pkg::op_t                       op_q;
	logic [DB-1:0]                       div_q;
	logic [DB-1:0]                       rem_q;
	logic [DB-1:0]                       quo_q;
	logic [dssr_pkg::DIV_CNT_BITS-1:0]   step_q;

	logic                                slot_free;
	logic                                finish;
	logic                                start;
	logic [DB:0]                         trial;
	logic                                fit;
	logic [DB-1:0]                       quo_nxt, rem_nxt, quo_dec;
	logic [CB-1:0]                       cmp_new;
	logic                                hit1, hit2, st1, st2;
	logic [dssr_pkg::PORT_BITS-1:0]      port_tick;

	assign slot_free = !out_valid_q || rsp.ready;

	// control
	always_comb begin
		state_d = state_q;
		pop     = 1'b0;
		start   = 1'b0;
		finish  = 1'b0;
		unique case (state_q)
			dssr_pkg::ST_IDLE: begin
				if (!q_stat.empty && slot_free) begin
					pop = 1'b1;
					if (head.op != dssr_pkg::OP_TICK && head.pps != '0) begin
						start   = 1'b1;
						state_d = dssr_pkg::ST_DIV;
					end
				end
			end
			dssr_pkg::ST_DIV: begin
				if (step_q == '1) begin
					finish  = 1'b1;
					state_d = dssr_pkg::ST_IDLE;
				end
			end
			default: state_d = dssr_pkg::ST_IDLE;
		endcase
	end

	// one restoring divide step per cycle
	always_comb begin
		trial   = {rem_q, quo_q[DB-1]} - {1'b0, div_q};
		fit     = !trial[DB];
		quo_nxt = {quo_q[DB-2:0], fit};
		rem_nxt = fit ? trial[DB-1:0] : {rem_q[DB-2:0], quo_q[DB-1]};
		quo_dec = quo_nxt - 1'b1;
		cmp_new = quo_dec[CB-1:0];
	end

	// tick datapath
	always_comb begin
		hit1      = (count1_q == cmp1_q);
		hit2      = (count2_q == cmp2_q);
		st1       = hit1 && en1_q;
		st2       = hit2 && en2_q;
		port_tick = {st2 ? dssr_pkg::m2_coil(ph2_q) : port_q[2*CW-1:CW],
			st1 ? dssr_pkg::m1_coil(ph1_q) : port_q[CW-1:0]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dssr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_rate_q <= dssr_pkg::TICK_RATE_RESET;
			count1_q    <= '0;
			count2_q    <= '0;
			cmp1_q      <= dssr_pkg::COMPARE_RESET;
			cmp2_q      <= dssr_pkg::COMPARE_RESET;
			en1_q       <= 1'b0;
			en2_q       <= 1'b0;
			ph1_q       <= '0;
			ph2_q       <= '0;
			port_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.we && cfg.index == dssr_pkg::REG_TICK_RATE) begin
				tick_rate_q <= cfg.data[DB-1:0];
			end
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			if (pop && head.op == dssr_pkg::OP_TICK) begin
				count1_q    <= hit1 ? '0 : count1_q + 1'b1;
				count2_q    <= hit2 ? '0 : count2_q + 1'b1;
				if (st1) begin
					ph1_q <= ph1_q + 1'b1;
				end
				if (st2) begin
					ph2_q <= ph2_q + 1'b1;
				end
				port_q      <= port_tick;
				out_valid_q <= 1'b1;
			end else if (pop && !start) begin
				// zero rate: compare cleared, enable untouched
				if (head.op == dssr_pkg::OP_BOTH || head.op == dssr_pkg::OP_MOTOR1) begin
					cmp1_q <= '0;
				end
				if (head.op == dssr_pkg::OP_BOTH || head.op == dssr_pkg::OP_MOTOR2) begin
					cmp2_q <= '0;
				end
				out_valid_q <= 1'b1;
			end else if (finish) begin
				if (op_q == dssr_pkg::OP_BOTH || op_q == dssr_pkg::OP_MOTOR1) begin
					cmp1_q <= cmp_new;
					en1_q  <= 1'b1;
				end
				if (op_q == dssr_pkg::OP_BOTH || op_q == dssr_pkg::OP_MOTOR2) begin
					cmp2_q <= cmp_new;
					en2_q  <= 1'b1;
				end
				out_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= head.op;
			div_q  <= head.pps;
			quo_q  <= tick_rate_q;
			rem_q  <= '0;
			step_q <= '0;
		end else if (state_q == dssr_pkg::ST_DIV) begin
			quo_q  <= quo_nxt;
			rem_q  <= rem_nxt;
			step_q <= step_q + 1'b1;
		end
		if (pop && head.op == dssr_pkg::OP_TICK) begin
			out_port_q <= port_tick;
			out_st1_q  <= st1;
			out_st2_q  <= st2;
		end else if ((pop && !start) || finish) begin
			out_port_q <= port_q;
			out_st1_q  <= 1'b0;
			out_st2_q  <= 1'b0;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.port_value     = out_port_q;
	assign rsp.motor1_stepped = out_st1_q;
	assign rsp.motor2_stepped = out_st2_q;

endmodule

// File: hdl/dual_stepper_steering_rate_gen.sv
// Two-channel stepper rate generator. A tick word advances both 8-bit compare
// timers and steps each enabled motor whose timer matches; a steering word sets
// one or both step rates from the signed line error and reloads the compare as
// tick_rate / rate - 1. Every word returns one result word with the port value
// and the two stepped flags. A tick word or a steering word that sets a zero
// rate needs no divide; one that sets a nonzero rate holds the execution
// stage for the load and 16 iterations of the radix-2 divider, and no word
// leaves the queue meanwhile. A two-entry queue sits between the input
// decoder and the execution stage, and a result register drives the output,
// so the input takes up to two more words while a result waits.
module dual_stepper_steering_rate_gen (
	input  logic                                 clk,
	input  logic                                 arst_n,
	dssr_req_if.sink                             req,
	dssr_rsp_if.source                           rsp,
	input  logic                                 cfg_we,
	input  logic [dssr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [dssr_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	dssr_pkg::cfg_wr_t     cfg;
	dssr_pkg::queue_stat_t q_stat;
	dssr_pkg::cmd_t        push_cmd;
	dssr_pkg::cmd_t        head;
	logic                  push;
	logic                  pop;

	assign cfg.we    = cfg_we;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	dssr_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.req    (req),
		.q_stat (q_stat),
		.push   (push),
		.cmd    (push_cmd)
	);

	dssr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	dssr_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.head   (head),
		.q_stat (q_stat),
		.pop    (pop),
		.rsp    (rsp)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_stat.full)
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_stat.empty)
		else $error("queue pop while empty");

	a_m1_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.motor1_stepped |-> $onehot(rsp.port_value[3:0]))
		else $error("motor 1 coils not one-hot after step");

	a_m2_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.motor2_stepped |-> $onehot(rsp.port_value[7:4]))
		else $error("motor 2 coils not one-hot after step");
`endif

endmodule

// File: sim/tb_dual_stepper_steering_rate_gen.sv
`timescale 1ns / 100ps

module tb_dual_stepper_steering_rate_gen;
	import dssr_pkg::*;

	localparam logic REQ_TICK  = 1'b0;
	localparam logic REQ_STEER = 1'b1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 3'd5;

	localparam int DIR_ROWS      = 32;
	localparam int PHASES        = 7;
	localparam int PHASE_WORDS   = 250;
	localparam int SETTLE_CYCLES = 4;
	localparam int TAIL_CYCLES   = 40;
	localparam int HOLD_AT       = 1350;
	localparam int HOLD_CYCLES   = 300;
	localparam int LIMIT_NS      = 2_000_000;

	typedef struct packed {
		logic [PORT_BITS-1:0] port;
		logic                 s1;
		logic                 s2;
	} coil_word_t;

	typedef enum logic [1:0] {
		ROW_WORD,
		ROW_WORD_CHK,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		row_kind_t               kind;
		logic                    req_type;
		logic [ERR_BITS-1:0]     err;
		logic [CFG_IDX_BITS-1:0] reg_idx;
		logic [CFG_DATA_BITS-1:0] reg_val;
		coil_word_t              want;
	} plan_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0]  cfg_index;
	logic [CFG_DATA_BITS-1:0] cfg_data;

	dssr_req_if req_bus ();
	dssr_rsp_if rsp_bus ();

	dual_stepper_steering_rate_gen dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_bus),
		.rsp       (rsp_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// shadow of the block's registers and timers
	logic [BASE_BITS-1:0]  speed_base = BASE_RESET;
	logic [GAIN_BITS-1:0]  gain_one   = GAIN_SMALL_RESET;
	logic [GAIN_BITS-1:0]  gain_two   = GAIN_MID_RESET;
	logic [GAIN_BITS-1:0]  gain_three = GAIN_LARGE_RESET;
	logic [DIV_BITS-1:0]   tick_hz    = TICK_RATE_RESET;
	logic [COUNT_BITS-1:0] m1_count = '0, m2_count = '0;
	logic [COUNT_BITS-1:0] m1_cmp = COMPARE_RESET, m2_cmp = COMPARE_RESET;
	logic                  m1_en = 1'b0, m2_en = 1'b0;
	logic [PHASE_BITS-1:0] m1_phase = '0, m2_phase = '0;
	logic [PORT_BITS-1:0]  coils = '0;

	coil_word_t coil_words_due[$];
	int mismatch_count = 0;
	int words_out = 0;
	bit calm = 1'b0;

	plan_row_t plan [DIR_ROWS] = '{
		'{ROW_CFG,      REQ_TICK,  8'h00, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD_CHK, REQ_STEER, 8'h00, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD_CHK, REQ_TICK,  8'h55, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD_CHK, REQ_TICK,  8'hAA, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_CFG,      REQ_TICK,  8'h00, REG_BASE_SPEED, 16'd1023,  '0},
		'{ROW_WORD_CHK, REQ_STEER, 8'h00, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD_CHK, REQ_STEER, 8'h80, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD_CHK, REQ_STEER, 8'h7F, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_TICK,  8'hFF, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_TICK,  8'h00, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_TICK,  8'hFF, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_TICK,  8'h00, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_TICK,  8'h0F, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_CFG,      REQ_TICK,  8'h00, REG_GAIN_SMALL, 16'd255,   '0},
		'{ROW_WORD,     REQ_STEER, 8'hFF, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_CFG,      REQ_TICK,  8'h00, REG_GAIN_MID,   16'd0,     '0},
		'{ROW_WORD,     REQ_STEER, 8'h02, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_STEER, 8'hFE, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_STEER, 8'h01, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_STEER, 8'hFD, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_CFG,      REQ_TICK,  8'h00, REG_TICK_RATE,  16'd1,     '0},
		'{ROW_WORD,     REQ_STEER, 8'h03, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_CFG,      REQ_TICK,  8'h00, CFG_IDX_SPARE,  16'hFFFF,  '0},
		'{ROW_CFG,      REQ_TICK,  8'h00, REG_TICK_RATE,  16'hFFFF,  '0},
		'{ROW_WORD,     REQ_STEER, 8'hFF, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_TICK,  8'hF0, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_TICK,  8'h3C, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_TICK,  8'hC3, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_CFG,      REQ_TICK,  8'h00, REG_GAIN_LARGE, 16'd255,   '0},
		'{ROW_WORD,     REQ_STEER, 8'h80, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_TICK,  8'h00, REG_BASE_SPEED, 16'd0,     '0},
		'{ROW_WORD,     REQ_TICK,  8'hFF, REG_BASE_SPEED, 16'd0,     '0}
	};

	initial clk = 1'b0;
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [COUNT_BITS-1:0] rate_cmp(input int unsigned pps);
		int unsigned q;
		if (pps == 0)
			return '0;
		q = tick_hz / pps;
		return COUNT_BITS'(q - 1);
	endfunction

	function automatic coil_word_t coil_word_after(input logic rt, input logic [ERR_BITS-1:0] err);
		coil_word_t  w;
		int unsigned mag;
		int unsigned gain;
		int unsigned pps;
		logic        hit;
		w.s1 = 1'b0;
		w.s2 = 1'b0;
		mag = err[ERR_BITS-1] ? 256 - err : err;
		if (rt == REQ_STEER) begin
			if (mag == 0) begin
				m1_cmp = rate_cmp(speed_base);
				m2_cmp = rate_cmp(speed_base);
				if (speed_base != 0) begin
					m1_en = 1'b1;
					m2_en = 1'b1;
				end
			end else begin
				gain = (mag == 1) ? gain_one : (mag == 2) ? gain_two : gain_three;
				pps = speed_base + mag * gain;
				if (err[ERR_BITS-1]) begin
					m1_cmp = rate_cmp(pps);
					if (pps != 0)
						m1_en = 1'b1;
				end else begin
					m2_cmp = rate_cmp(pps);
					if (pps != 0)
						m2_en = 1'b1;
				end
			end
		end else begin
			hit = (m1_count == m1_cmp);
			m1_count = hit ? '0 : m1_count + 1'b1;
			if (hit && m1_en) begin
				coils[3:0] = 4'b1000 >> m1_phase;
				m1_phase = m1_phase + 1'b1;
				w.s1 = 1'b1;
			end
			hit = (m2_count == m2_cmp);
			m2_count = hit ? '0 : m2_count + 1'b1;
			if (hit && m2_en) begin
				coils[7:4] = 4'b0001 << m2_phase;
				m2_phase = m2_phase + 1'b1;
				w.s2 = 1'b1;
			end
		end
		w.port = coils;
		return w;
	endfunction

	// entered and left at a falling edge
	task automatic send_word(input logic rt, input logic [ERR_BITS-1:0] err,
			input bit typed, input coil_word_t want);
		int gap;
		coil_word_t pred;
		gap = calm ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			req_bus.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_bus.valid = 1'b1;
		req_bus.req_type = rt;
		req_bus.line_error = err;
		do @(posedge clk); while (!req_bus.ready);
		pred = coil_word_after(rt, err);
		coil_words_due.push_back(typed ? want : pred);
		@(negedge clk);
	endtask

	task automatic drain();
		req_bus.valid = 1'b0;
		while (coil_words_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_BASE_SPEED: speed_base = val[BASE_BITS-1:0];
			REG_GAIN_SMALL: gain_one = val[GAIN_BITS-1:0];
			REG_GAIN_MID:   gain_two = val[GAIN_BITS-1:0];
			REG_GAIN_LARGE: gain_three = val[GAIN_BITS-1:0];
			REG_TICK_RATE:  tick_hz = val[DIV_BITS-1:0];
			default: ;
		endcase
	endtask

	task automatic program_phase(input int ph);
		logic [CFG_DATA_BITS-1:0] base_v, s_v, m_v, l_v, tick_v;
		case (ph)
			0: begin
				base_v = 16'd1;
				s_v = 16'd0;
				m_v = 16'd0;
				l_v = 16'd0;
				tick_v = 16'd1;
			end
			1: begin
				base_v = 16'hFFFF;
				s_v = 16'hFFFF;
				m_v = 16'hFFFF;
				l_v = 16'hFFFF;
				tick_v = 16'hFFFF;
			end
			default: begin
				base_v = {6'($urandom), 10'($urandom_range(1, 1023))};
				s_v = 16'($urandom);
				m_v = 16'($urandom);
				l_v = 16'($urandom);
				tick_v = $urandom_range(0, 1) ? 16'($urandom_range(1, 65535))
					: 16'($urandom_range(1, 4000));
				if (ph == 2)
					base_v[BASE_BITS-1:0] = '0;
				if (ph == 3)
					tick_v = '0;
			end
		endcase
		write_reg(REG_BASE_SPEED, base_v);
		write_reg(REG_GAIN_SMALL, s_v);
		write_reg(REG_GAIN_MID, m_v);
		write_reg(REG_GAIN_LARGE, l_v);
		write_reg(REG_TICK_RATE, tick_v);
		if (ph >= 2)
			write_reg(CFG_IDX_SPARE + 3'($urandom_range(0, 2)), 16'($urandom));
	endtask

	task automatic check_word();
		coil_word_t got;
		coil_word_t want;
		got.port = rsp_bus.port_value;
		got.s1 = rsp_bus.motor1_stepped;
		got.s2 = rsp_bus.motor2_stepped;
		if (coil_words_due.size() == 0) begin
			mismatch_count++;
			if (mismatch_count <= 10)
				$display("unexpected word: port=%h m1=%b m2=%b", got.port, got.s1, got.s2);
		end else begin
			want = coil_words_due.pop_front();
			if (got.port !== want.port || got.s1 !== want.s1 || got.s2 !== want.s2) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("word %0d: exp port=%h m1=%b m2=%b, got port=%h m1=%b m2=%b",
						words_out, want.port, want.s1, want.s2, got.port, got.s1, got.s2);
			end
		end
	endtask

	// result side
	initial begin
		int gap;
		rsp_bus.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			if (words_out == HOLD_AT) begin
				rsp_bus.ready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			gap = calm ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				rsp_bus.ready = 1'b0;
				repeat (gap) @(negedge clk);
			end
			rsp_bus.ready = 1'b1;
			do @(posedge clk); while (!rsp_bus.valid);
			check_word();
			words_out++;
			@(negedge clk);
		end
	end

	initial begin
		logic                rt;
		logic [ERR_BITS-1:0] err;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_BASE_SPEED;
		cfg_data = '0;
		req_bus.valid = 1'b0;
		req_bus.req_type = REQ_TICK;
		req_bus.line_error = '0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == ROW_CFG) begin
				drain();
				write_reg(plan[i].reg_idx, plan[i].reg_val);
			end else begin
				send_word(plan[i].req_type, plan[i].err, plan[i].kind == ROW_WORD_CHK,
					plan[i].want);
			end
		end

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			program_phase(ph);
			calm = (ph % 3 == 2);
			repeat (PHASE_WORDS) begin
				rt = ($urandom_range(0, 5) == 0) ? REQ_STEER : REQ_TICK;
				if (rt == REQ_STEER && $urandom_range(0, 1))
					err = ERR_BITS'(int'($urandom_range(0, 8)) - 4);
				else
					err = ERR_BITS'($urandom);
				send_word(rt, err, 1'b0, '0);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (mismatch_count == 0 && coil_words_due.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#LIMIT_NS;
		$display("tb: failure");
		$finish;
	end

endmodule
